/* sv/higs_pkg.sv */
// ----------------------------------------------------------------------------
// HID global item state package
// Tags, status codes and the layout of the global table.
// ----------------------------------------------------------------------------
package higs_pkg;

  localparam int unsigned PAGE_SHIFT = 16;

  typedef enum logic [3:0] {
    TAG_USAGE_PAGE   = 4'd0,
    TAG_LOGICAL_MIN  = 4'd1,
    TAG_LOGICAL_MAX  = 4'd2,
    TAG_PHYSICAL_MIN = 4'd3,
    TAG_PHYSICAL_MAX = 4'd4,
    TAG_UNIT_EXP     = 4'd5,
    TAG_UNIT         = 4'd6,
    TAG_REPORT_SIZE  = 4'd7,
    TAG_REPORT_ID    = 4'd8,
    TAG_REPORT_COUNT = 4'd9,
    TAG_PUSH         = 4'd10,
    TAG_POP          = 4'd11
  } tag_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_STACK_ERR   = 2'd1,
    ST_ID_CONFLICT = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0]        usage_page;
    logic signed [31:0] logical_min;
    logic signed [31:0] logical_max;
    logic signed [31:0] physical_min;
    logic signed [31:0] physical_max;
    logic [31:0]        unit_exponent;
    logic [31:0]        unit_code;
    logic [31:0]        report_size;
    logic [31:0]        report_id;
    logic [31:0]        report_count;
  } table_t;

  localparam int unsigned TABLE_W = $bits(table_t);

  typedef struct packed {
    status_t     status;
    table_t      tbl;
    logic [31:0] node_report_id;
  } result_t;

endpackage

/* sv/higs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module higs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/hid_global_item_state_top.sv */
// The result is registered in the output register, or in the skid register while stalled.
// Throughput: one item per cycle unless in_stall; pushes, pops and others go back to back.
// The saved-table stack is a RAM; the entry on top is read every cycle ahead of use.
// A skid register takes one more item while the output is stalled; in_stall is high
// while it holds one. Reset (rst_n low, synchronous) clears the table, stack level
// and node ID and sets report_node_attached; saved stack entries are not cleared.
// ----------------------------------------------------------------------------
// HID global item state
// Applies decoded HID global items to the current global table with a
// bounded push/pop stack and reports the table after every item.
// ----------------------------------------------------------------------------
module hid_global_item_state_top
  import higs_pkg::*;
#(
  parameter int STACK_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_tag,
  input  logic [31:0]        in_unsigned_value,
  input  logic signed [31:0] in_signed_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_usage_page,
  output logic signed [31:0] out_logical_min,
  output logic signed [31:0] out_logical_max,
  output logic signed [31:0] out_physical_min,
  output logic signed [31:0] out_physical_max,
  output logic [31:0]        out_unit_exponent,
  output logic [31:0]        out_unit_code,
  output logic [31:0]        out_report_size,
  output logic [31:0]        out_report_id,
  output logic [31:0]        out_report_count,
  output logic [31:0]        out_node_report_id,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_report_node_attached
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

  table_t          tbl_r, tbl_nxt;
  logic [LW-1:0]   level_r, level_nxt;
  logic [31:0]     node_id_r, node_id_nxt;
  logic            attached_r;
  logic            top_from_ram_r;
  logic [TABLE_W-1:0] ram_rdata;
  table_t          top_tbl;
  logic            ram_we;
  logic [LW-1:0]   level_dec;
  logic            in_xfer;
  logic            out_xfer;
  status_t         status;
  result_t         res;
  result_t         out_r;
  result_t         skid_r;
  logic            out_valid_r;
  logic            skid_valid_r;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  assign top_tbl   = top_from_ram_r ? table_t'(ram_rdata) : tbl_r;
  assign level_dec = level_nxt - LW'(1);

  always_comb begin
    tbl_nxt     = tbl_r;
    level_nxt   = level_r;
    node_id_nxt = node_id_r;
    status      = ST_OK;
    ram_we      = 1'b0;
    if (in_xfer) begin
      unique case (in_tag)
        TAG_USAGE_PAGE:   tbl_nxt.usage_page   = in_unsigned_value << PAGE_SHIFT;
        TAG_LOGICAL_MIN:  tbl_nxt.logical_min  = in_signed_value;
        TAG_LOGICAL_MAX:  tbl_nxt.logical_max  = in_signed_value;
        TAG_PHYSICAL_MIN: tbl_nxt.physical_min = in_signed_value;
        TAG_PHYSICAL_MAX: tbl_nxt.physical_max = in_signed_value;
        TAG_UNIT_EXP:     tbl_nxt.unit_exponent = in_unsigned_value;
        TAG_UNIT:         tbl_nxt.unit_code    = in_unsigned_value;
        TAG_REPORT_SIZE:  tbl_nxt.report_size  = in_unsigned_value;
        TAG_REPORT_COUNT: tbl_nxt.report_count = in_unsigned_value;
        TAG_REPORT_ID: begin
          tbl_nxt.report_id = in_unsigned_value;
          if (attached_r) begin
            if (node_id_r == '0) begin
              node_id_nxt = in_unsigned_value;
            end else if (node_id_r != in_unsigned_value) begin
              status = ST_ID_CONFLICT;
            end
          end
        end
        TAG_PUSH: begin
          if (level_r == LEVEL_FULL) begin
            status = ST_STACK_ERR;
          end else begin
            ram_we    = 1'b1;
            level_nxt = level_r + LW'(1);
          end
        end
        TAG_POP: begin
          if (level_r == '0) begin
            status = ST_STACK_ERR;
          end else begin
            tbl_nxt   = top_tbl;
            level_nxt = level_r - LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.status         = status;
    res.tbl            = tbl_nxt;
    res.node_report_id = attached_r ? node_id_nxt : '0;
  end

  // The top entry is read every cycle; right after a push it equals the live table.
  higs_ram #(
    .WIDTH (TABLE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (level_r[AW-1:0]),
    .wdata (tbl_r),
    .raddr (level_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r          <= '0;
      level_r        <= '0;
      node_id_r      <= '0;
      attached_r     <= 1'b1;
      top_from_ram_r <= 1'b0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      tbl_r          <= tbl_nxt;
      level_r        <= level_nxt;
      node_id_r      <= node_id_nxt;
      top_from_ram_r <= !ram_we;
      if (cfg_valid && cfg_ready) begin
        attached_r <= cfg_report_node_attached;
      end
      if (skid_valid_r) begin
        if (out_xfer) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_xfer) begin
        if (out_valid_r && !out_xfer) begin
          skid_valid_r <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_r <= skid_r;
      end
    end else if (in_xfer) begin
      if (out_valid_r && !out_xfer) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_usage_page     = out_r.tbl.usage_page;
  assign out_logical_min    = out_r.tbl.logical_min;
  assign out_logical_max    = out_r.tbl.logical_max;
  assign out_physical_min   = out_r.tbl.physical_min;
  assign out_physical_max   = out_r.tbl.physical_max;
  assign out_unit_exponent  = out_r.tbl.unit_exponent;
  assign out_unit_code      = out_r.tbl.unit_code;
  assign out_report_size    = out_r.tbl.report_size;
  assign out_report_id      = out_r.tbl.report_id;
  assign out_report_count   = out_r.tbl.report_count;
  assign out_node_report_id = out_r.node_report_id;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_FULL)
    else $error("stack level beyond depth");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer full while output register empty");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tag == TAG_PUSH && level_r == LEVEL_FULL |=> $stable(level_r))
    else $error("push on a full stack changed the level");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tag == TAG_POP && level_r != '0 |=> level_r == $past(level_r) - LW'(1))
    else $error("pop did not lower the level by one");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID global item state testbench
// Drives global items with random idling and output stalls, predicts the
// table, status and node ID after every item, and checks each result.
// ----------------------------------------------------------------------------
module testbench;
  import higs_pkg::*;

  localparam int STACK_DEPTH = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [3:0] TAG_RESERVED_FIRST = 4'd12;
  localparam logic [3:0] TAG_RESERVED_LAST = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_tag = '0;
  logic [31:0] in_unsigned_value = '0;
  logic signed [31:0] in_signed_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [31:0] out_usage_page;
  logic signed [31:0] out_logical_min;
  logic signed [31:0] out_logical_max;
  logic signed [31:0] out_physical_min;
  logic signed [31:0] out_physical_max;
  logic [31:0] out_unit_exponent;
  logic [31:0] out_unit_code;
  logic [31:0] out_report_size;
  logic [31:0] out_report_id;
  logic [31:0] out_report_count;
  logic [31:0] out_node_report_id;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_report_node_attached = 1'b1;

  table_t gtab = '0;
  table_t saved_tables [STACK_DEPTH];
  int stack_level = 0;
  logic [31:0] node_id = '0;
  logic node_attached = 1'b1;
  result_t table_results_due [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit idling_on = 1'b0;
  bit hold_on = 1'b0;
  int stall_left = 0;
  event hold_kick;

  hid_global_item_state_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_tag(in_tag),
    .in_unsigned_value(in_unsigned_value),
    .in_signed_value(in_signed_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_usage_page(out_usage_page),
    .out_logical_min(out_logical_min),
    .out_logical_max(out_logical_max),
    .out_physical_min(out_physical_min),
    .out_physical_max(out_physical_max),
    .out_unit_exponent(out_unit_exponent),
    .out_unit_code(out_unit_code),
    .out_report_size(out_report_size),
    .out_report_id(out_report_id),
    .out_report_count(out_report_count),
    .out_node_report_id(out_node_report_id),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_report_node_attached(cfg_report_node_attached)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic result_t apply_global_item(logic [3:0] tag, logic [31:0] uval,
                                                logic signed [31:0] sval);
    result_t res;
    status_t st;
    st = ST_OK;
    case (tag)
      TAG_USAGE_PAGE:   gtab.usage_page = uval << PAGE_SHIFT;
      TAG_LOGICAL_MIN:  gtab.logical_min = sval;
      TAG_LOGICAL_MAX:  gtab.logical_max = sval;
      TAG_PHYSICAL_MIN: gtab.physical_min = sval;
      TAG_PHYSICAL_MAX: gtab.physical_max = sval;
      TAG_UNIT_EXP:     gtab.unit_exponent = uval;
      TAG_UNIT:         gtab.unit_code = uval;
      TAG_REPORT_SIZE:  gtab.report_size = uval;
      TAG_REPORT_COUNT: gtab.report_count = uval;
      TAG_REPORT_ID: begin
        gtab.report_id = uval;
        if (node_attached) begin
          if (node_id == '0) begin
            node_id = uval;
          end else if (node_id != uval) begin
            st = ST_ID_CONFLICT;
          end
        end
      end
      TAG_PUSH: begin
        if (stack_level >= STACK_DEPTH) begin
          st = ST_STACK_ERR;
        end else begin
          saved_tables[stack_level] = gtab;
          stack_level++;
        end
      end
      TAG_POP: begin
        if (stack_level == 0) begin
          st = ST_STACK_ERR;
        end else begin
          stack_level--;
          gtab = saved_tables[stack_level];
        end
      end
      default: ;
    endcase
    res.status = st;
    res.tbl = gtab;
    res.node_report_id = node_attached ? node_id : '0;
    return res;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100) begin
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (table_results_due.size() == 0) begin
        report_mismatch("result with none due, status", 32'(out_status), '0);
      end else begin
        want = table_results_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_usage_page !== want.tbl.usage_page)
          report_mismatch("usage_page", out_usage_page, want.tbl.usage_page);
        if (out_logical_min !== want.tbl.logical_min)
          report_mismatch("logical_min", out_logical_min, want.tbl.logical_min);
        if (out_logical_max !== want.tbl.logical_max)
          report_mismatch("logical_max", out_logical_max, want.tbl.logical_max);
        if (out_physical_min !== want.tbl.physical_min)
          report_mismatch("physical_min", out_physical_min, want.tbl.physical_min);
        if (out_physical_max !== want.tbl.physical_max)
          report_mismatch("physical_max", out_physical_max, want.tbl.physical_max);
        if (out_unit_exponent !== want.tbl.unit_exponent)
          report_mismatch("unit_exponent", out_unit_exponent, want.tbl.unit_exponent);
        if (out_unit_code !== want.tbl.unit_code)
          report_mismatch("unit_code", out_unit_code, want.tbl.unit_code);
        if (out_report_size !== want.tbl.report_size)
          report_mismatch("report_size", out_report_size, want.tbl.report_size);
        if (out_report_id !== want.tbl.report_id)
          report_mismatch("report_id", out_report_id, want.tbl.report_id);
        if (out_report_count !== want.tbl.report_count)
          report_mismatch("report_count", out_report_count, want.tbl.report_count);
        if (out_node_report_id !== want.node_report_id)
          report_mismatch("node_report_id", out_node_report_id, want.node_report_id);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The long hold-off is counted on rising edges so the receiver sees it settled.
  always begin
    @(hold_kick);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  task automatic send_item(input logic [3:0] tag, input logic [31:0] uval,
                           input logic [31:0] sval);
    @(negedge clk);
    in_valid <= 1'b1;
    in_tag <= tag;
    in_unsigned_value <= uval;
    in_signed_value <= sval;
    do @(posedge clk); while (in_stall);
    table_results_due.push_back(apply_global_item(tag, uval, sval));
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    pause_input(1);
    while (table_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_node_attached(input logic value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_report_node_attached <= value;
    do @(posedge clk); while (!cfg_ready);
    node_attached = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int pick;
    logic [3:0] tag;
    logic [31:0] uval;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      tag = 4'($urandom_range(int'(TAG_REPORT_COUNT), int'(TAG_USAGE_PAGE)));
    end else if (pick < 76) begin
      tag = TAG_PUSH;
    end else if (pick < 92) begin
      tag = TAG_POP;
    end else begin
      tag = 4'($urandom_range(int'(TAG_RESERVED_LAST), int'(TAG_RESERVED_FIRST)));
    end
    uval = random_word();
    // Small IDs keep matches and conflicts both frequent once the node ID is set.
    if (tag == TAG_REPORT_ID && $urandom_range(0, 3) != 0) uval = $urandom_range(1, 3);
    send_item(tag, uval, random_word());
  endtask

  task automatic test_report_id();
    send_item(TAG_REPORT_ID, 32'd0, 32'd0);
    send_item(TAG_REPORT_ID, 32'd5, 32'd5);
    send_item(TAG_REPORT_ID, 32'd5, 32'd5);
    send_item(TAG_REPORT_ID, 32'd7, 32'd7);
    write_node_attached(1'b0);
    send_item(TAG_REPORT_ID, 32'd9, 32'd9);
    write_node_attached(1'b1);
    send_item(TAG_REPORT_ID, 32'd5, 32'd5);
    drain_results();
  endtask

  task automatic test_field_extremes();
    send_item(TAG_USAGE_PAGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(TAG_LOGICAL_MIN, 32'h8000_0000, 32'h8000_0000);
    send_item(TAG_LOGICAL_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(TAG_PHYSICAL_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(TAG_PHYSICAL_MAX, 32'h0000_0000, 32'h0000_0000);
    send_item(TAG_UNIT_EXP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(TAG_UNIT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(TAG_REPORT_SIZE, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(TAG_REPORT_COUNT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(TAG_RESERVED_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_stack_limits();
    send_item(TAG_POP, 32'd0, 32'd0);
    send_item(TAG_LOGICAL_MIN, 32'd1, 32'sd1);
    send_item(TAG_PUSH, 32'd0, 32'd0);
    send_item(TAG_LOGICAL_MIN, 32'd2, -32'sd2);
    repeat (STACK_DEPTH - 1) send_item(TAG_PUSH, 32'd0, 32'd0);
    send_item(TAG_PUSH, 32'd0, 32'd0);
    send_item(TAG_POP, 32'd0, 32'd0);
    send_item(TAG_POP, 32'd0, 32'd0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    idling_on = with_idle;
    repeat (count) begin
      send_random_item();
      if (idling_on && $urandom_range(0, 7) == 0) pause_input($urandom_range(1, 7));
    end
    drain_results();
  endtask

  task automatic test_output_backpressure();
    idling_on = 1'b0;
    -> hold_kick;
    repeat (40) send_random_item();
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_report_id();
    test_field_extremes();
    test_stack_limits();
    test_random_traffic(400, 1'b1);
    write_node_attached(1'b0);
    test_random_traffic(350, 1'b1);
    write_node_attached(1'b1);
    test_output_backpressure();
    test_random_traffic(350, 1'b1);
    test_random_traffic(400, 1'b0);
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* hid_global_item_state_top.f */
sv/higs_pkg.sv
sv/higs_ram.sv
sv/hid_global_item_state_top.sv
dv/testbench.sv
